[rtl/spc_pkg.sv]
`default_nettype none

package spc_pkg;

  // Field and datapath widths
  localparam int unsigned SPEED_W  = 16;  // wheel speed, average, target
  localparam int unsigned GAIN_W   = 16;  // Q8.8 gains
  localparam int unsigned IMAX_W   = 24;  // integral limit
  localparam int unsigned INTEG_W  = 25;  // accumulated error
  localparam int unsigned SMOOTH_W = 9;   // Q1.8 smoothing weight
  localparam int unsigned DMAX_W   = 15;  // duty limit
  localparam int unsigned DUTY_W   = 16;  // output duty
  localparam int unsigned RAW_W    = 32;  // raw and smoothed duty
  localparam int unsigned ERR_W    = 17;  // speed error
  localparam int unsigned FRAC_W   = 8;   // fraction bits of gains and weight
  localparam int unsigned ACC_W    = 42;  // multiply-accumulate width
  localparam int unsigned MPLR_W   = 16;  // serial multiplier operand width
  localparam int unsigned SHR_W    = ACC_W - FRAC_W;

  localparam int unsigned WINDOW_LEN_DEF = 5;
  localparam int unsigned SUM_W_DEF      = SPEED_W + $clog2(WINDOW_LEN_DEF);

  // Configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned IDX_W  = APB_AW - 2;

  localparam logic [IDX_W-1:0] REG_TARGET_SPEED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SMOOTH_FACTOR = 3'd4;
  localparam logic [IDX_W-1:0] REG_DUTY_MAX      = 3'd5;

  localparam logic [IMAX_W-1:0]   IMAX_RST   = '1;
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 9'd256;
  localparam logic [DMAX_W-1:0]   DMAX_RST   = '1;

  localparam logic signed [ACC_W-1:0] TRUNC_ADJ = ACC_W'((1 << FRAC_W) - 1);

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } spc_in_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0]  duty;
    logic signed [SPEED_W-1:0] avg_speed;
  } spc_out_t;

  typedef struct packed {
    logic load;   // take new operands
    logic clear;  // zero the accumulator with the load
    logic step;   // one multiplier bit
  } spc_mac_ctrl_t;

  // Divide by 2^FRAC_W, truncating toward zero
  function automatic logic signed [SHR_W-1:0] shr_trunc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    b = a + (a[ACC_W-1] ? TRUNC_ADJ : '0);
    return signed'(b[ACC_W-1:FRAC_W]);
  endfunction

endpackage

`default_nettype wire

[rtl/spc_div.sv]
`default_nettype none

// Restoring divider by a constant, one quotient bit per cycle
module spc_div #(
  parameter int unsigned DIVISOR = spc_pkg::WINDOW_LEN_DEF,
  parameter int unsigned DVD_W   = spc_pkg::SUM_W_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             done_o
);

  localparam int unsigned REM_W = $clog2(DIVISOR);
  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    ge      = (rem_sh >= DIV_K);
    rem_sub = ge ? (rem_sh - DIV_K) : rem_sh;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift the quotient bit in where the dividend bit left
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = rem_sub[REM_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

[rtl/spc_mac.sv]
`default_nettype none

// Shift-and-add multiply-accumulate, one multiplier bit per cycle
module spc_mac (
  input  logic                                clk_i,
  input  spc_pkg::spc_mac_ctrl_t              ctrl_i,
  input  logic signed [spc_pkg::ACC_W-1:0]    mcand_i,
  input  logic        [spc_pkg::MPLR_W-1:0]   mplr_i,
  output logic signed [spc_pkg::ACC_W-1:0]    acc_o
);

  logic signed [spc_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [spc_pkg::ACC_W-1:0]  mcand_q, mcand_d;
  logic        [spc_pkg::MPLR_W-1:0] mplr_q, mplr_d;

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    if (ctrl_i.load) begin
      mcand_d = mcand_i;
      mplr_d  = mplr_i;
      if (ctrl_i.clear) begin
        acc_d = '0;
      end
    end else if (ctrl_i.step) begin
      acc_d   = acc_q + (mplr_q[0] ? mcand_q : '0);
      mcand_d = mcand_q <<< 1;
      mplr_d  = mplr_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[rtl/speed_pi_controller.sv]
// Processing: the serial window divider forms the average, then the shared bit-serial
//   multiply-accumulate works through its products (16 + 16 + 9 + 9 steps); a result
//   left waiting holds the hand-over.
// Flow: one input transaction in flight at a time; a new sample is taken only when idle.
// Reset: asynchronous, active low; clears window, integral, previous duty, loads defaults.
`default_nettype none

module speed_pi_controller #(
  parameter int unsigned WINDOW_LEN = spc_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // speed sample channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  spc_pkg::spc_in_t            in_data_i,
  // duty result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output spc_pkg::spc_out_t           out_data_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spc_pkg::APB_AW-1:0]  paddr,
  input  logic [spc_pkg::APB_DW-1:0]  pwdata,
  output logic [spc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned SPEED_W   = spc_pkg::SPEED_W;
  localparam int unsigned WIN_DEPTH = WINDOW_LEN - 1;
  localparam int unsigned SUM_W     = SPEED_W + $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W     = $clog2(spc_pkg::MPLR_W);
  localparam int unsigned ACC_W     = spc_pkg::ACC_W;
  localparam int unsigned RAW_W     = spc_pkg::RAW_W;
  localparam int unsigned INTEG_W   = spc_pkg::INTEG_W;
  localparam int unsigned ERR_W     = spc_pkg::ERR_W;
  localparam int unsigned LIM_W     = INTEG_W + 1;

  localparam logic [CNT_W-1:0] GAIN_LAST   = CNT_W'(spc_pkg::GAIN_W - 1);
  localparam logic [CNT_W-1:0] WEIGHT_LAST = CNT_W'(spc_pkg::SMOOTH_W - 1);

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;   // wait for a sample
  localparam logic [3:0] S_DIV    = 4'd1;   // window sum / WINDOW_LEN
  localparam logic [3:0] S_ERR    = 4'd2;   // target - average
  localparam logic [3:0] S_INT    = 4'd3;   // integrate and clamp, load P * err
  localparam logic [3:0] S_MULP   = 4'd4;
  localparam logic [3:0] S_LDI    = 4'd5;   // load I * integral
  localparam logic [3:0] S_MULI   = 4'd6;
  localparam logic [3:0] S_RAW    = 4'd7;   // scale and saturate raw duty
  localparam logic [3:0] S_LDK    = 4'd8;   // load K * raw
  localparam logic [3:0] S_MULK   = 4'd9;
  localparam logic [3:0] S_LDV    = 4'd10;  // load (1 - K) * previous
  localparam logic [3:0] S_MULV   = 4'd11;
  localparam logic [3:0] S_SMOOTH = 4'd12;  // scale blended duty
  localparam logic [3:0] S_OUT    = 4'd13;  // clamp and hand over

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; pready is tied
  // high so every transaction completes without wait states.
  // ---------------------------------------------------------------------------
  logic [SPEED_W-1:0]           target_q;
  logic [spc_pkg::GAIN_W-1:0]   pgain_q, igain_q;
  logic [spc_pkg::IMAX_W-1:0]   imax_q;
  logic [spc_pkg::SMOOTH_W-1:0] smooth_q;
  logic [spc_pkg::DMAX_W-1:0]   dmax_q;
  logic                         cfg_we;
  logic [spc_pkg::IDX_W-1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[spc_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      pgain_q  <= '0;
      igain_q  <= '0;
      imax_q   <= spc_pkg::IMAX_RST;
      smooth_q <= spc_pkg::SMOOTH_ONE;
      dmax_q   <= spc_pkg::DMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spc_pkg::REG_TARGET_SPEED:  target_q <= pwdata[SPEED_W-1:0];
        spc_pkg::REG_PROP_GAIN:     pgain_q  <= pwdata[spc_pkg::GAIN_W-1:0];
        spc_pkg::REG_INTEG_GAIN:    igain_q  <= pwdata[spc_pkg::GAIN_W-1:0];
        spc_pkg::REG_INTEGRAL_MAX:  imax_q   <= pwdata[spc_pkg::IMAX_W-1:0];
        spc_pkg::REG_SMOOTH_FACTOR: smooth_q <= pwdata[spc_pkg::SMOOTH_W-1:0];
        spc_pkg::REG_DUTY_MAX:      dmax_q   <= pwdata[spc_pkg::DMAX_W-1:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      spc_pkg::REG_TARGET_SPEED:  prdata = spc_pkg::APB_DW'(target_q);
      spc_pkg::REG_PROP_GAIN:     prdata = spc_pkg::APB_DW'(pgain_q);
      spc_pkg::REG_INTEG_GAIN:    prdata = spc_pkg::APB_DW'(igain_q);
      spc_pkg::REG_INTEGRAL_MAX:  prdata = spc_pkg::APB_DW'(imax_q);
      spc_pkg::REG_SMOOTH_FACTOR: prdata = spc_pkg::APB_DW'(smooth_q);
      spc_pkg::REG_DUTY_MAX:      prdata = spc_pkg::APB_DW'(dmax_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Loop state and working registers
  // ---------------------------------------------------------------------------
  logic [3:0]                state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [SPEED_W-1:0] win_q [WIN_DEPTH];
  logic signed [SPEED_W-1:0] win_d [WIN_DEPTH];
  logic signed [SUM_W-1:0]   win_sum_q, win_sum_d;   // sum of the stored means
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [RAW_W-1:0]   prev_q, prev_d;          // smoothed duty, unclamped
  logic                      sum_neg_q, sum_neg_d;
  logic signed [SPEED_W-1:0] avg_q, avg_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [RAW_W-1:0]   raw_q, raw_d;
  logic                      out_valid_q, out_valid_d;
  spc_pkg::spc_out_t         out_data_q, out_data_d;

  logic                      in_fire;
  logic signed [SPEED_W:0]   lr_sum, lr_adj;
  logic signed [SPEED_W-1:0] mean;
  logic signed [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]          sum_mag;
  logic [SUM_W-1:0]          div_quot;
  logic                      div_done;
  logic [SPEED_W-1:0]        quot16;
  logic signed [LIM_W-1:0]   integ_sum, ilim_pos, ilim_neg;
  logic signed [spc_pkg::SHR_W-1:0] acc_shr;
  logic [spc_pkg::SMOOTH_W-1:0] k_sat, k_inv;
  logic signed [RAW_W-1:0]   dlim_pos, dlim_neg, duty_clamped;

  spc_pkg::spc_mac_ctrl_t            mac_ctrl;
  logic signed [ACC_W-1:0]           mac_mcand;
  logic [spc_pkg::MPLR_W-1:0]        mac_mplr;
  logic signed [ACC_W-1:0]           mac_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Mean of the two wheels, truncated toward zero: bias negatives by one
  assign lr_sum  = (SPEED_W + 1)'(in_data_i.left_speed) + (SPEED_W + 1)'(in_data_i.right_speed);
  assign lr_adj  = lr_sum + (SPEED_W + 1)'(lr_sum[SPEED_W]);
  assign mean    = SPEED_W'(lr_adj >>> 1);
  assign sum_new = SUM_W'(mean) + win_sum_q;
  assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  // Quotient magnitude never exceeds 2^15, so sixteen bits carry the sign too
  assign quot16 = div_quot[SPEED_W-1:0];

  // Integral clamp limits
  assign ilim_pos  = signed'(LIM_W'(imax_q));
  assign ilim_neg  = -ilim_pos;
  assign integ_sum = LIM_W'(integ_q) + LIM_W'(err_q);

  assign acc_shr = spc_pkg::shr_trunc(mac_acc);

  // A weight above one saturates at one
  assign k_sat = (smooth_q > spc_pkg::SMOOTH_ONE) ? spc_pkg::SMOOTH_ONE : smooth_q;
  assign k_inv = spc_pkg::SMOOTH_ONE - k_sat;

  assign dlim_pos = signed'(RAW_W'(dmax_q));
  assign dlim_neg = -dlim_pos;
  assign duty_clamped = (prev_q > dlim_pos) ? dlim_pos :
                        (prev_q < dlim_neg) ? dlim_neg : prev_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    win_d       = win_q;
    win_sum_d   = win_sum_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    sum_neg_d   = sum_neg_q;
    avg_d       = avg_q;
    err_d       = err_q;
    raw_d       = raw_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mac_ctrl    = '0;
    mac_mcand   = '0;
    mac_mplr    = '0;

    unique case (state_q) inside
      S_IDLE: begin
        if (in_fire) begin
          // Advance the window: drop the oldest mean, append this one
          for (int i = 0; i < int'(WIN_DEPTH) - 1; i++) begin
            win_d[i] = win_q[i + 1];
          end
          win_d[WIN_DEPTH-1] = mean;
          win_sum_d = sum_new - SUM_W'(win_q[0]);
          sum_neg_d = sum_new[SUM_W-1];
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = sum_neg_q ? SPEED_W'(-quot16) : SPEED_W'(quot16);
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        err_d   = ERR_W'(signed'(target_q)) - ERR_W'(avg_q);
        state_d = S_INT;
      end
      S_INT: begin
        // Anti-windup: hold the integral inside +-integral_max
        if (integ_sum > ilim_pos) begin
          integ_d = INTEG_W'(ilim_pos);
        end else if (integ_sum < ilim_neg) begin
          integ_d = INTEG_W'(ilim_neg);
        end else begin
          integ_d = INTEG_W'(integ_sum);
        end
        mac_ctrl.load  = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_mcand      = ACC_W'(err_q);
        mac_mplr       = spc_pkg::MPLR_W'(pgain_q);
        cnt_d          = '0;
        state_d        = S_MULP;
      end
      S_MULP, S_MULI: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == GAIN_LAST) begin
          cnt_d   = '0;
          state_d = (state_q == S_MULP) ? S_LDI : S_RAW;
        end
      end
      S_LDI: begin
        mac_ctrl.load = 1'b1;
        mac_mcand     = ACC_W'(integ_q);
        mac_mplr      = spc_pkg::MPLR_W'(igain_q);
        state_d       = S_MULI;
      end
      S_RAW: begin
        // Saturate the scaled sum to 32-bit signed
        if (acc_shr[spc_pkg::SHR_W-1:RAW_W-1] == '0 ||
            acc_shr[spc_pkg::SHR_W-1:RAW_W-1] == '1) begin
          raw_d = acc_shr[RAW_W-1:0];
        end else begin
          raw_d = acc_shr[spc_pkg::SHR_W-1] ? {1'b1, {(RAW_W-1){1'b0}}}
                                            : {1'b0, {(RAW_W-1){1'b1}}};
        end
        state_d = S_LDK;
      end
      S_LDK: begin
        mac_ctrl.load  = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_mcand      = ACC_W'(raw_q);
        mac_mplr       = spc_pkg::MPLR_W'(k_sat);
        state_d        = S_MULK;
      end
      S_MULK, S_MULV: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == WEIGHT_LAST) begin
          cnt_d   = '0;
          state_d = (state_q == S_MULK) ? S_LDV : S_SMOOTH;
        end
      end
      S_LDV: begin
        mac_ctrl.load = 1'b1;
        mac_mcand     = ACC_W'(prev_q);
        mac_mplr      = spc_pkg::MPLR_W'(k_inv);
        state_d       = S_MULV;
      end
      S_SMOOTH: begin
        // A convex blend of two 32-bit values stays in 32 bits
        prev_d  = acc_shr[RAW_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hand over once the result register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          out_data_d.duty      = duty_clamped[spc_pkg::DUTY_W-1:0];
          out_data_d.avg_speed = avg_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      win_sum_q   <= '0;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(WIN_DEPTH); i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      win_sum_q   <= win_sum_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_neg_q  <= sum_neg_d;
    avg_q      <= avg_d;
    err_q      <= err_d;
    raw_q      <= raw_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Serial units
  // ---------------------------------------------------------------------------
  spc_div #(
    .DIVISOR (WINDOW_LEN),
    .DVD_W   (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (sum_mag),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  spc_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .mcand_i (mac_mcand),
    .mplr_i  (mac_mplr),
    .acc_o   (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("sample accepted while a tick was in progress");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the wait state");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result appeared without the sequencer handing it over");

  a_integ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == S_INT) |-> (LIM_W'(integ_q) <= ilim_pos && LIM_W'(integ_q) >= ilim_neg))
    else $error("integral escaped its clamp");

endmodule

`default_nettype wire
